[sv/gf16_pkg.sv]
// shared types, constants and helpers for the gf(2^16) arithmetic unit
package gf16_pkg;

  localparam int ELEM_W  = 16;
  localparam int CMD_W   = 3;
  localparam int SWEEP_W = ELEM_W + 1;

  // low terms of x^16 + x^12 + x^3 + x + 1
  localparam logic [ELEM_W-1:0] POLY_LOW  = 16'h100B;
  // multiplicative group order, also the last antilog index
  localparam logic [ELEM_W-1:0] GRP_ORDER = 16'hFFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_MUL = 3'd1,
    CMD_DIV = 3'd2,
    CMD_EXP = 3'd3,
    CMD_LOG = 3'd4
  } cmd_t;

  typedef logic [ELEM_W-1:0] elem_t;

  // one write into a table memory
  typedef struct packed {
    logic  we;
    elem_t addr;
    elem_t data;
  } gf16_wr_t;

  // multiply an element by alpha = x
  function automatic elem_t times_alpha(input elem_t v);
    elem_t s;
    s = {v[ELEM_W-2:0], 1'b0};
    if (v[ELEM_W-1]) begin
      s = s ^ POLY_LOW;
    end
    return s;
  endfunction

endpackage

[sv/gf16_if.sv]
// item channels of the gf(2^16) arithmetic unit
interface gf16_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] operand_a;
  logic [15:0] operand_b;

  modport source (output valid, output command, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input command, input operand_a, input operand_b,
                  output ready);
endinterface

interface gf16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result;
  logic        divide_by_zero;

  modport source (output valid, output result, output divide_by_zero, input ready);
  modport sink   (input valid, input result, input divide_by_zero, output ready);
endinterface

[sv/gf16_init.sv]
// sweep that fills the log and antilog tables after reset by stepping alpha
module gf16_init (
  input  logic               clk,
  input  logic               rst_n,
  output gf16_pkg::gf16_wr_t log_wr,
  output gf16_pkg::gf16_wr_t exp_wr,
  output logic               done
);
  import gf16_pkg::*;

  logic [SWEEP_W-1:0] idx_r, idx_nxt;
  elem_t              pw_r, pw_nxt;

  assign done = idx_r[SWEEP_W-1];

  always_comb begin
    idx_nxt = idx_r;
    pw_nxt  = pw_r;
    if (!done) begin
      idx_nxt = idx_r + SWEEP_W'(1);
      pw_nxt  = times_alpha(pw_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      pw_r  <= elem_t'(1);
    end else begin
      idx_r <= idx_nxt;
      pw_r  <= pw_nxt;
    end
  end

  // antilog[i] = alpha^i for every index, log[alpha^i] = i below the group order
  always_comb begin
    exp_wr.we   = !done;
    exp_wr.addr = idx_r[ELEM_W-1:0];
    exp_wr.data = pw_r;
    log_wr.we   = !done && (idx_r[ELEM_W-1:0] != GRP_ORDER);
    log_wr.addr = pw_r;
    log_wr.data = idx_r[ELEM_W-1:0];
  end

endmodule

[sv/gf16_log_mem.sv]
// log table memory, one write port and two registered read ports
module gf16_log_mem (
  input  logic               clk,
  input  gf16_pkg::gf16_wr_t wr,
  input  logic               rd_en,
  input  gf16_pkg::elem_t    addr_a,
  input  gf16_pkg::elem_t    addr_b,
  output gf16_pkg::elem_t    q_a,
  output gf16_pkg::elem_t    q_b
);
  import gf16_pkg::*;

  elem_t mem [0:(1 << ELEM_W) - 1];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_a <= mem[addr_a];
      q_b <= mem[addr_b];
    end
  end

endmodule

[sv/gf16_exp_mem.sv]
// antilog table memory, one write port and one registered read port
module gf16_exp_mem (
  input  logic               clk,
  input  gf16_pkg::gf16_wr_t wr,
  input  logic               rd_en,
  input  gf16_pkg::elem_t    addr,
  output gf16_pkg::elem_t    q
);
  import gf16_pkg::*;

  elem_t mem [0:(1 << ELEM_W) - 1];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q <= mem[addr];
    end
  end

endmodule

[sv/gf2_16_arithmetic_unit.sv]
// gf(2^16) arithmetic unit: add by xor, multiply, divide, exp and log through log/antilog tables
//
//   channel   dir   handshake          payload
//   in_item   in    valid / ready      command[2:0], operand_a[15:0], operand_b[15:0]
//   out_item  out   valid / ready      result[15:0], divide_by_zero
//
// one item per cycle sustained while out_item.ready holds high; the result passes through
//   three register stages: log table read, index add and reduce mod 65535, antilog read
// after reset the tables are filled by a sweep over every index, in_item.ready low throughout
// each stage moves when the one after it is empty or moving, so bubbles close up
//   and new items are taken while a finished result waits on out_item.ready, until stages 1 and 2 fill
module gf2_16_arithmetic_unit (
  input  logic       clk,
  input  logic       rst_n,
  gf16_in_if.sink    in_item,
  gf16_out_if.source out_item
);
  import gf16_pkg::*;

  // table fill
  gf16_wr_t log_wr, exp_wr;
  logic     init_done;

  gf16_init u_init (
    .clk    (clk),
    .rst_n  (rst_n),
    .log_wr (log_wr),
    .exp_wr (exp_wr),
    .done   (init_done)
  );

  // stage enables, back to front
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  logic in_fire;

  assign en3     = !v3_r || out_item.ready;
  assign en2     = !v2_r || en3;
  assign en1     = !v1_r || en2;
  assign in_item.ready = init_done && en1;
  assign in_fire = in_item.valid && in_item.ready;

  // stage 1: log table lookups of both operands
  logic [CMD_W-1:0] cmd1_r;
  elem_t            a1_r, b1_r;
  elem_t            log_qa, log_qb;

  gf16_log_mem u_log_mem (
    .clk    (clk),
    .wr     (log_wr),
    .rd_en  (en1),
    .addr_a (in_item.operand_a),
    .addr_b (in_item.operand_b),
    .q_a    (log_qa),
    .q_b    (log_qb)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1_r <= in_item.command;
      a1_r   <= in_item.operand_a;
      b1_r   <= in_item.operand_b;
    end
  end

  // stage 1 logic: antilog index and the results that need no antilog
  logic               a_zero, b_zero;
  elem_t              la, lb;
  logic [SWEEP_W-1:0] idx_sum, idx_red;
  elem_t              exp_addr;
  logic               use_exp;
  elem_t              alt_res;
  logic               dz;

  always_comb begin
    a_zero = (a1_r == '0);
    b_zero = (b1_r == '0);
    // log of zero reads as zero, that entry is never filled
    la = a_zero ? '0 : log_qa;
    lb = b_zero ? '0 : log_qb;

    // divide uses la + (65535 - lb), and 65535 - lb is the complement
    if (cmd1_r == CMD_DIV) begin
      idx_sum = {1'b0, la} + {1'b0, ~lb};
    end else begin
      idx_sum = {1'b0, la} + {1'b0, lb};
    end
    // alpha has order 65535, fold the index back below it
    if (idx_sum >= {1'b0, GRP_ORDER}) begin
      idx_red = idx_sum - {1'b0, GRP_ORDER};
    end else begin
      idx_red = idx_sum;
    end

    exp_addr = idx_red[ELEM_W-1:0];
    use_exp  = 1'b0;
    alt_res  = '0;
    dz       = 1'b0;
    case (cmd1_r)
      CMD_ADD: begin
        alt_res = a1_r ^ b1_r;
      end
      CMD_MUL: begin
        use_exp = !a_zero && !b_zero;
      end
      CMD_DIV: begin
        if (b_zero) begin
          // zero divisor passes the dividend through and flags it
          alt_res = a1_r;
          dz      = 1'b1;
        end else begin
          use_exp = !a_zero;
        end
      end
      CMD_EXP: begin
        exp_addr = a1_r;
        use_exp  = 1'b1;
      end
      CMD_LOG: begin
        alt_res = la;
      end
      default: begin
        alt_res = '0;
      end
    endcase
  end

  // stage 2: antilog address register
  elem_t addr2_r, alt2_r;
  logic  use_exp2_r, dz2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      addr2_r    <= exp_addr;
      alt2_r     <= alt_res;
      use_exp2_r <= use_exp;
      dz2_r      <= dz;
    end
  end

  // stage 3: antilog read data and the output register
  elem_t exp_q, alt3_r;
  logic  use_exp3_r, dz3_r;

  gf16_exp_mem u_exp_mem (
    .clk   (clk),
    .wr    (exp_wr),
    .rd_en (en3),
    .addr  (addr2_r),
    .q     (exp_q)
  );

  always_ff @(posedge clk) begin
    if (en3) begin
      alt3_r     <= alt2_r;
      use_exp3_r <= use_exp2_r;
      dz3_r      <= dz2_r;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_fire;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  assign out_item.valid          = v3_r;
  assign out_item.result         = use_exp3_r ? exp_q : alt3_r;
  assign out_item.divide_by_zero = dz3_r;

endmodule
